>>> design/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and character classes for the sentence segmenter
// Holds the buffer depth, the request and response payloads, command codes
// and the code-unit classification functions used at the head of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

	localparam int DEPTH = 64;
	localparam int CW    = $clog2(DEPTH + 1);

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_FLUSH  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic REG_MIN = 1'b0;
	localparam logic REG_MAX = 1'b1;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] code_unit;
	} req_t;

	typedef struct packed {
		logic [15:0] out_unit;
		logic        chunk_end;
	} rsp_t;

	typedef struct packed {
		logic          rot;
		logic          app;
		logic [CW-1:0] fill;
	} cell_ctl_t;

	function automatic logic is_ws(input logic [15:0] c);
		return (c >= 16'h0009 && c <= 16'h000d) || c == 16'h0020 || c == 16'h0085 ||
			c == 16'h00a0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200a) ||
			c == 16'h2028 || c == 16'h2029 || c == 16'h202f || c == 16'h205f ||
			c == 16'h3000;
	endfunction

	function automatic logic is_mark(input logic [15:0] c);
		return c == 16'h002e || c == 16'h0021 || c == 16'h003f || c == 16'h003b ||
			c == 16'h000a || c == 16'h3002 || c == 16'hff01 || c == 16'hff1f ||
			c == 16'hff1b || c == 16'h2026;
	endfunction

	function automatic logic is_closer(input logic [15:0] c);
		return is_ws(c) || c == 16'h2019 || c == 16'h201d || c == 16'h3009 ||
			c == 16'h300b || c == 16'h300d || c == 16'h300f || c == 16'h3011 ||
			c == 16'hff09;
	endfunction

	function automatic logic is_soft(input logic [15:0] c);
		return is_ws(c) || c == 16'h002c || c == 16'hff0c || c == 16'h3001 ||
			c == 16'hff1a;
	endfunction

endpackage

`default_nettype wire

>>> design/sentence_chunk_segmenter.sv
// ----------------------------------------------------------------------------
// sentence_chunk_segmenter: cuts a UTF-16 stream into sentence chunks
// Ring of code-unit cells rotated past a scan/emit sequencer at the head.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_t (cmd, code_unit)
//   rsp      out  rsp_valid/rsp_stall  rsp_t (out_unit, chunk_end)
//   cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// each cut search rotates the full ring once past the head
// each cut then removes one unit per cycle, holding while a loaded unit waits on rsp
// an item runs a search per chunk it cuts, plus a last search when units remain
// clear, unused command and flush of an empty buffer start no search
// req is stalled until the item's last search or cut is done; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module sentence_chunk_segmenter
	import ssc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire req_t       req,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output rsp_t            rsp,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [6:0] cfg_data
);

	logic [15:0] unit_q [DEPTH];
	cell_ctl_t   ctl;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		ssc_cell u_cell (
			.clk    (clk),
			.rot    (ctl.rot),
			.load   (ctl.app && ctl.fill == CW'(i)),
			.din    (req.code_unit),
			.nbr    (unit_q[(i + 1) % DEPTH]),
			.unit_q (unit_q[i])
		);
	end

	ssc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (unit_q[0]),
		.ctl       (ctl)
	);

endmodule

`default_nettype wire

>>> design/ssc_cell.sv
// ----------------------------------------------------------------------------
// ssc_cell: one buffer cell
// Holds one code unit; loads an appended unit or takes its neighbor's unit
// when the chain rotates.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_cell
	import ssc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        rot,
	input  wire logic        load,
	input  wire logic [15:0] din,
	input  wire logic [15:0] nbr,
	output logic      [15:0] unit_q
);

	always_ff @(posedge clk) begin
		if (load) begin
			unit_q <= din;
		end else if (rot) begin
			unit_q <= nbr;
		end
	end

endmodule

`default_nettype wire

>>> design/ssc_ctrl.sv
// ----------------------------------------------------------------------------
// ssc_ctrl: scan and emit sequencer
// Watches the head cell while the chain rotates, finds the cut, then emits
// the trimmed chunk through the output register and drops the cut units.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_ctrl
	import ssc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire req_t        req,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output rsp_t             rsp,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [6:0]  cfg_data,
	input  wire logic [15:0] head,
	output cell_ctl_t        ctl
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [1:0]    state_q;
	logic [CW-1:0] fill_q, p_q, lo_q, hi_q, cut_q, chi_q, soft_q, shi_q, mhi_q, e_q;
	logic          flush_q, run_q, done_q, found_q;
	logic [6:0]    min_q, max_q;
	logic          out_v_q;
	rsp_t          out_q;

	logic [CW-1:0] mn, mx, mx0, len, hi_n, lo_n, rest;
	logic          vpos, ws, emit_pos, blocked, rot, load_out;

	always_comb begin
		if (min_q == 7'd0) begin
			mn = CW'(1);
		end else if (CW'(min_q) > DEPTH_C) begin
			mn = DEPTH_C;
		end else begin
			mn = CW'(min_q);
		end
		mx0 = (CW'(max_q) < mn) ? mn : CW'(max_q);
		mx  = (mx0 > DEPTH_C) ? DEPTH_C : mx0;
	end

	assign vpos = p_q < fill_q;
	assign ws   = is_ws(head);
	assign len  = (hi_q == '0) ? '0 : hi_q - lo_q;
	assign rest = fill_q - cut_q;

	always_comb begin
		hi_n = hi_q;
		lo_n = lo_q;
		if (vpos && !ws) begin
			if (hi_q == '0) begin
				lo_n = p_q;
			end
			hi_n = p_q + CW'(1);
		end
	end

	assign emit_pos = chi_q != '0 && e_q >= lo_q && e_q < chi_q;
	assign blocked  = emit_pos && out_v_q && rsp_stall;
	assign load_out = state_q == ST_EMIT && !blocked && emit_pos;

	always_comb begin
		case (state_q)
			ST_SCAN: rot = p_q < DEPTH_C;
			ST_EMIT: rot = !blocked;
			default: rot = 1'b0;
		endcase
	end

	assign req_stall = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign rsp_valid = out_v_q;
	assign rsp       = out_q;
	assign ctl.rot   = rot;
	assign ctl.app   = state_q == ST_IDLE && req_valid && req.cmd == CMD_APPEND &&
		fill_q < DEPTH_C;
	assign ctl.fill  = fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 7'd1;
			max_q <= 7'd64;
		end else if (cfg_valid) begin
			if (cfg_index == REG_MIN) begin
				min_q <= cfg_data;
			end else begin
				max_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			flush_q <= 1'b0;
			p_q     <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			cut_q   <= '0;
			chi_q   <= '0;
			soft_q  <= '0;
			shi_q   <= '0;
			mhi_q   <= '0;
			e_q     <= '0;
			out_v_q <= 1'b0;
			out_q   <= '0;
		end else begin
			if (out_v_q && !rsp_stall && !load_out) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					p_q     <= '0;
					lo_q    <= '0;
					hi_q    <= '0;
					run_q   <= 1'b0;
					done_q  <= 1'b0;
					found_q <= 1'b0;
					soft_q  <= '0;
					shi_q   <= '0;
					mhi_q   <= '0;
					if (req_valid) begin
						case (req.cmd)
							CMD_APPEND: begin
								flush_q <= 1'b0;
								if (fill_q < DEPTH_C) begin
									fill_q <= fill_q + CW'(1);
								end
								state_q <= ST_SCAN;
							end
							CMD_FLUSH: begin
								flush_q <= 1'b1;
								if (fill_q != '0) begin
									state_q <= ST_SCAN;
								end
							end
							CMD_CLEAR: fill_q <= '0;
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (vpos && !done_q) begin
						if (!(run_q && is_closer(head))) begin
							if (run_q && len >= mn) begin
								found_q <= 1'b1;
								done_q  <= 1'b1;
								cut_q   <= p_q;
								chi_q   <= hi_q;
							end else begin
								run_q <= is_mark(head);
							end
						end
					end
					if (p_q == fill_q && !done_q && run_q) begin
						done_q <= 1'b1;
						if (flush_q && len >= mn) begin
							found_q <= 1'b1;
							cut_q   <= p_q;
							chi_q   <= hi_q;
						end
					end
					if (vpos && is_soft(head) && p_q >= mn && p_q < mx) begin
						soft_q <= p_q + CW'(1);
						shi_q  <= hi_n;
					end
					if (vpos && p_q == mx - CW'(1)) begin
						mhi_q <= hi_n;
					end
					hi_q <= hi_n;
					lo_q <= lo_n;
					p_q  <= p_q + CW'(1);
					if (p_q == DEPTH_C) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					e_q <= '0;
					if (found_q) begin
						state_q <= ST_EMIT;
					end else if (fill_q >= mx) begin
						state_q <= ST_EMIT;
						if (soft_q != '0) begin
							cut_q <= soft_q;
							chi_q <= shi_q;
						end else begin
							cut_q <= mx;
							chi_q <= mhi_q;
						end
					end else if (flush_q) begin
						state_q <= ST_EMIT;
						cut_q   <= fill_q;
						chi_q   <= hi_q;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (!blocked) begin
						if (emit_pos) begin
							out_v_q             <= 1'b1;
							out_q.out_unit  <= head;
							out_q.chunk_end <= e_q + CW'(1) == chi_q;
						end
						e_q <= e_q + CW'(1);
						if (e_q + CW'(1) == cut_q) begin
							fill_q  <= rest;
							p_q     <= '0;
							lo_q    <= '0;
							hi_q    <= '0;
							run_q   <= 1'b0;
							done_q  <= 1'b0;
							found_q <= 1'b0;
							soft_q  <= '0;
							shi_q   <= '0;
							mhi_q   <= '0;
							state_q <= (rest == '0) ? ST_IDLE : ST_SCAN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("fill count beyond depth");

	a_idle_still: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !rot)
		else $error("chain rotates while idle");

	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_EMIT && !(out_v_q && !rsp_stall)) |=> out_v_q == $past(out_v_q))
		else $error("result loaded outside emit");

	a_cut_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> (cut_q != '0 && cut_q <= fill_q && chi_q <= cut_q))
		else $error("bad cut position");

endmodule

`default_nettype wire
